>>> src/fve_pkg.sv
// shared types and constants for the flow verdict enforcer
`timescale 1ns / 1ps
package fve_pkg;

   localparam int unsigned KEY_W      = 48;
   localparam int unsigned HASH_W     = 16;
   localparam int unsigned STAT_COUNT = 5;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [1:0] RULE_DENY     = 2'd0;
   localparam logic [1:0] RULE_ALLOW    = 2'd1;
   localparam logic [1:0] RULE_RESTRICT = 2'd2;

   localparam logic [2:0] STATUS_APPLIED = 3'd0;
   localparam logic [2:0] STATUS_EXPIRED = 3'd1;
   localparam logic [2:0] STATUS_NONE    = 3'd2;
   localparam logic [2:0] STATUS_NOT_TCP = 3'd3;
   localparam logic [2:0] STATUS_STORED  = 3'd4;
   localparam logic [2:0] STATUS_FULL    = 3'd5;

   localparam int unsigned STAT_ATTEMPTS = 0;
   localparam int unsigned STAT_BLOCKED  = 1;
   localparam int unsigned STAT_ALLOWED  = 2;
   localparam int unsigned STAT_EXPIRED  = 3;
   localparam int unsigned STAT_MISSING  = 4;

   typedef enum logic [1:0] {
      KIND_LOOKUP,
      KIND_NOT_TCP,
      KIND_WRITE
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] set_idx;
      logic [63:0]       now_ns;
      logic [1:0]        verdict;
      logic [31:0]       principal;
      logic [63:0]       expiry;
   } item_type;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [1:0]        verdict;
      logic [31:0]       principal;
      logic [63:0]       expiry;
      logic [63:0]       hits;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_REDUCE
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_MATCH,
      B_FINISH
   } back_state_type;

endpackage

>>> src/fve_front.sv
// front end: takes a transaction, classifies it, computes key and set
`timescale 1ns / 1ps
module fve_front #(
   parameter int unsigned TABLE_SETS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_action,
   input  logic              req_is_tcp,
   input  logic [31:0]       req_dest_addr,
   input  logic [15:0]       req_dest_port,
   input  logic [63:0]       req_now_ns,
   input  logic [1:0]        req_new_verdict,
   input  logic [31:0]       req_new_principal,
   input  logic [63:0]       req_new_expiry_ns,
   input  logic              q_full,
   output logic              q_push,
   output fve_pkg::item_type q_item
);

   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / TABLE_SETS);
   localparam logic [31:0] SETS  = 32'(TABLE_SETS);

   fve_pkg::front_state_type state_ff, state_in;
   fve_pkg::item_type        item_ff, item_in;
   logic [15:0]              hash_ff, hash_in;
   logic [47:0]              prod_ff;
   logic [31:0]              qn, rem;
   logic                     take;

   assign take = start && (state_ff == fve_pkg::F_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fve_pkg::F_IDLE:   if (start) state_in = fve_pkg::F_MUL;
         fve_pkg::F_MUL:    state_in = fve_pkg::F_REDUCE;
         fve_pkg::F_REDUCE: if (!q_full) state_in = fve_pkg::F_IDLE;
         default:           state_in = fve_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      busy   = (state_ff != fve_pkg::F_IDLE);
      q_push = (state_ff == fve_pkg::F_REDUCE) && !q_full;
   end

   // classify and latch the transaction
   always_comb begin
      item_in           = item_ff;
      hash_in           = hash_ff;
      if (take) begin
         if (req_action)       item_in.kind = fve_pkg::KIND_WRITE;
         else if (req_is_tcp)  item_in.kind = fve_pkg::KIND_LOOKUP;
         else                  item_in.kind = fve_pkg::KIND_NOT_TCP;
         item_in.key       = {req_dest_addr, req_dest_port};
         item_in.set_idx   = '0;
         item_in.now_ns    = req_now_ns;
         item_in.verdict   = (req_new_verdict == 2'd3) ? fve_pkg::RULE_RESTRICT
                                                       : req_new_verdict;
         item_in.principal = req_new_principal;
         item_in.expiry    = req_new_expiry_ns;
         hash_in = req_dest_addr[31:16] ^ req_dest_addr[15:0] ^ req_dest_port;
      end
   end

   // set = hash mod sets, via reciprocal and one correction step
   always_comb begin
      qn  = 32'(prod_ff[47:32]) * SETS;
      rem = 32'(hash_ff) - qn;
      if (rem >= SETS) rem = rem - SETS;
      q_item         = item_ff;
      q_item.set_idx = rem[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fve_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff <= item_in;
      hash_ff <= hash_in;
      prod_ff <= 48'(hash_ff) * 48'(RECIP);
   end

endmodule

>>> src/fve_queue.sv
// short queue between front and back
`timescale 1ns / 1ps
module fve_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fve_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output fve_pkg::item_type pop_item
);

   localparam int unsigned PTR_W = $clog2(fve_pkg::QUEUE_DEPTH);

   fve_pkg::item_type   slot_ff [fve_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]      cnt_ff, cnt_in;

   assign full     = (cnt_ff == (PTR_W+1)'(fve_pkg::QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_item = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = wr_ff + 1'b1;
      if (pop)  rd_in = rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= push_item;
   end

endmodule

>>> src/fve_back.sv
// back end: set memory, match, verdict, hit and statistic update
`timescale 1ns / 1ps
module fve_back #(
   parameter int unsigned TABLE_SETS = 256,
   parameter int unsigned TABLE_WAYS = 4
) (
   input  logic              clock,
   input  logic              reset,
   output logic              clearing,
   input  logic              q_empty,
   input  fve_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_strobe,
   output logic              rsp_connect_allowed,
   output logic [1:0]        rsp_verdict_taken,
   output logic [31:0]       rsp_principal_taken,
   output logic [2:0]        rsp_status,
   output logic [63:0]       rsp_entry_hits,
   output logic [63:0]       rsp_attempts_seen,
   output logic [63:0]       rsp_blocked_seen,
   output logic [63:0]       rsp_allowed_seen,
   output logic [63:0]       rsp_expired_seen,
   output logic [63:0]       rsp_missing_seen
);

   localparam int unsigned SET_W = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
   localparam int unsigned WAY_W = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
   localparam int unsigned EW    = fve_pkg::ENTRY_W;
   localparam int unsigned ROW_W = TABLE_WAYS * EW;

   logic [ROW_W-1:0] mem [TABLE_SETS];
   logic [ROW_W-1:0] rdata_ff, wdata;
   logic [SET_W-1:0] addr, clr_ff, clr_in;
   logic             we;

   fve_pkg::back_state_type state_ff, state_in;
   fve_pkg::item_type       item_ff;
   logic                    found_ff, found_in, free_ff, free_in, live_ff, live_in;
   logic [WAY_W-1:0]        way_ff, way_in;
   fve_pkg::entry_type      sel_ff, sel_in, new_entry;
   logic [63:0]             stat_ff [fve_pkg::STAT_COUNT];
   logic [63:0]             stat_in [fve_pkg::STAT_COUNT];
   logic                    strobe_ff, allowed_ff, allowed_in;
   logic [1:0]              verdict_ff, verdict_in;
   logic [31:0]             principal_ff, principal_in;
   logic [2:0]              status_ff, status_in;
   logic [63:0]             hits_ff, hits_in;
   logic                    finish;

   assign finish = (state_ff == fve_pkg::B_FINISH);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fve_pkg::B_CLEAR:  if (clr_ff == SET_W'(TABLE_SETS - 1)) state_in = fve_pkg::B_IDLE;
         fve_pkg::B_IDLE:   if (!q_empty) state_in = fve_pkg::B_READ;
         fve_pkg::B_READ:   state_in = fve_pkg::B_MATCH;
         fve_pkg::B_MATCH:  state_in = fve_pkg::B_FINISH;
         fve_pkg::B_FINISH: state_in = fve_pkg::B_IDLE;
         default:           state_in = fve_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      clearing = (state_ff == fve_pkg::B_CLEAR);
      q_pop    = (state_ff == fve_pkg::B_IDLE) && !q_empty;
      clr_in   = clearing ? clr_ff + 1'b1 : clr_ff;
   end

   // way search over the registered row
   always_comb begin
      fve_pkg::entry_type e;
      found_in = 1'b0;
      free_in  = 1'b0;
      way_in   = '0;
      for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
         e = rdata_ff[w*EW +: EW];
         if (!e.valid && !found_in) begin
            free_in = 1'b1;
            way_in  = WAY_W'(w);
         end
      end
      for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
         e = rdata_ff[w*EW +: EW];
         if (e.valid && e.key == item_ff.key) begin
            found_in = 1'b1;
            way_in   = WAY_W'(w);
         end
      end
      sel_in  = rdata_ff[way_in*EW +: EW];
      live_in = (sel_in.expiry == 64'd0) || (item_ff.now_ns < sel_in.expiry);
   end

   // outcome and write-back
   always_comb begin
      for (int i = 0; i < fve_pkg::STAT_COUNT; i++) stat_in[i] = stat_ff[i];
      allowed_in   = 1'b0;
      verdict_in   = fve_pkg::RULE_DENY;
      principal_in = '0;
      status_in    = fve_pkg::STATUS_STORED;
      hits_in      = '0;
      we           = 1'b0;
      new_entry    = sel_ff;
      unique case (item_ff.kind)
         fve_pkg::KIND_WRITE: begin
            if (found_ff || free_ff) begin
               we                  = finish;
               new_entry.valid     = 1'b1;
               new_entry.key       = item_ff.key;
               new_entry.verdict   = item_ff.verdict;
               new_entry.principal = item_ff.principal;
               new_entry.expiry    = item_ff.expiry;
               new_entry.hits      = '0;
            end else begin
               status_in = fve_pkg::STATUS_FULL;
            end
         end
         fve_pkg::KIND_NOT_TCP: begin
            allowed_in = 1'b1;
            verdict_in = fve_pkg::RULE_ALLOW;
            status_in  = fve_pkg::STATUS_NOT_TCP;
         end
         default: begin
            verdict_in = fve_pkg::RULE_ALLOW;
            if (!found_ff) begin
               status_in = fve_pkg::STATUS_NONE;
               stat_in[fve_pkg::STAT_MISSING] = stat_ff[fve_pkg::STAT_MISSING] + 64'd1;
            end else if (live_ff) begin
               status_in      = fve_pkg::STATUS_APPLIED;
               verdict_in     = sel_ff.verdict;
               principal_in   = sel_ff.principal;
               new_entry.hits = sel_ff.hits + 64'd1;
               hits_in        = new_entry.hits;
               we             = finish;
            end else begin
               status_in = fve_pkg::STATUS_EXPIRED;
               stat_in[fve_pkg::STAT_EXPIRED] = stat_ff[fve_pkg::STAT_EXPIRED] + 64'd1;
            end
            stat_in[fve_pkg::STAT_ATTEMPTS] = stat_ff[fve_pkg::STAT_ATTEMPTS] + 64'd1;
            if (verdict_in == fve_pkg::RULE_DENY) begin
               stat_in[fve_pkg::STAT_BLOCKED] = stat_ff[fve_pkg::STAT_BLOCKED] + 64'd1;
            end else begin
               allowed_in = 1'b1;
               stat_in[fve_pkg::STAT_ALLOWED] = stat_ff[fve_pkg::STAT_ALLOWED] + 64'd1;
            end
         end
      endcase
      wdata = rdata_ff;
      wdata[way_ff*EW +: EW] = new_entry;
      if (clearing) begin
         wdata = '0;
         we    = 1'b1;
      end
      addr = clearing ? clr_ff : item_ff.set_idx[SET_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fve_pkg::B_CLEAR;
         clr_ff    <= '0;
         strobe_ff <= 1'b0;
         for (int i = 0; i < fve_pkg::STAT_COUNT; i++) stat_ff[i] <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         strobe_ff <= finish;
         if (finish) begin
            for (int i = 0; i < fve_pkg::STAT_COUNT; i++) stat_ff[i] <= stat_in[i];
         end
      end
      if (q_pop) item_ff <= q_item;
      found_ff <= found_in;
      free_ff  <= free_in;
      live_ff  <= live_in;
      way_ff   <= way_in;
      sel_ff   <= sel_in;
      if (finish) begin
         allowed_ff   <= allowed_in;
         verdict_ff   <= verdict_in;
         principal_ff <= principal_in;
         status_ff    <= status_in;
         hits_ff      <= hits_in;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_connect_allowed = allowed_ff;
   assign rsp_verdict_taken   = verdict_ff;
   assign rsp_principal_taken = principal_ff;
   assign rsp_status          = status_ff;
   assign rsp_entry_hits      = hits_ff;
   assign rsp_attempts_seen   = stat_ff[fve_pkg::STAT_ATTEMPTS];
   assign rsp_blocked_seen    = stat_ff[fve_pkg::STAT_BLOCKED];
   assign rsp_allowed_seen    = stat_ff[fve_pkg::STAT_ALLOWED];
   assign rsp_expired_seen    = stat_ff[fve_pkg::STAT_EXPIRED];
   assign rsp_missing_seen    = stat_ff[fve_pkg::STAT_MISSING];

endmodule

>>> src/flow_verdict_enforcer.sv
// top level of the exact-match flow verdict table
`timescale 1ns / 1ps
// exact-match flow verdict table keyed by destination address and port,
// TABLE_SETS sets of TABLE_WAYS ways. a transaction is taken when start is
// high and busy is low; each one yields exactly one result, shown for one
// cycle with rsp_strobe high, in order, and the receiver cannot stall it.
// after reset the table memory is swept clear one set per cycle, and busy
// stays high until the sweep is done. the front steps through latch, hash
// reciprocal multiply and modulo correction, and hands the transaction to
// a two-entry queue, waiting while the queue is full; the back steps
// through queue pop, set memory read, way match, and write-back and
// result. the back end handles one transaction at a time, finishing the
// read-modify-write of one set row through the single memory port before
// it pops the next; the front can take a new transaction once it has
// handed the last one to the queue.
module flow_verdict_enforcer #(
   parameter int unsigned TABLE_SETS = 256,
   parameter int unsigned TABLE_WAYS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic        req_is_tcp,
   input  logic [31:0] req_dest_addr,
   input  logic [15:0] req_dest_port,
   input  logic [63:0] req_now_ns,
   input  logic [1:0]  req_new_verdict,
   input  logic [31:0] req_new_principal,
   input  logic [63:0] req_new_expiry_ns,
   output logic        rsp_strobe,
   output logic        rsp_connect_allowed,
   output logic [1:0]  rsp_verdict_taken,
   output logic [31:0] rsp_principal_taken,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_entry_hits,
   output logic [63:0] rsp_attempts_seen,
   output logic [63:0] rsp_blocked_seen,
   output logic [63:0] rsp_allowed_seen,
   output logic [63:0] rsp_expired_seen,
   output logic [63:0] rsp_missing_seen
);

   // queue hand-off between front and back
   logic              q_push, q_pop, q_full, q_empty;
   fve_pkg::item_type push_item, pop_item;
   logic              front_busy, clearing;

   // no transaction during the clear sweep
   assign busy = front_busy || clearing;

   fve_front #(
      .TABLE_SETS (TABLE_SETS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start && !clearing),
      .busy              (front_busy),
      .req_action        (req_action),
      .req_is_tcp        (req_is_tcp),
      .req_dest_addr     (req_dest_addr),
      .req_dest_port     (req_dest_port),
      .req_now_ns        (req_now_ns),
      .req_new_verdict   (req_new_verdict),
      .req_new_principal (req_new_principal),
      .req_new_expiry_ns (req_new_expiry_ns),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_item            (push_item)
   );

   fve_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (pop_item)
   );

   fve_back #(
      .TABLE_SETS (TABLE_SETS),
      .TABLE_WAYS (TABLE_WAYS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .clearing            (clearing),
      .q_empty             (q_empty),
      .q_item              (pop_item),
      .q_pop               (q_pop),
      .rsp_strobe          (rsp_strobe),
      .rsp_connect_allowed (rsp_connect_allowed),
      .rsp_verdict_taken   (rsp_verdict_taken),
      .rsp_principal_taken (rsp_principal_taken),
      .rsp_status          (rsp_status),
      .rsp_entry_hits      (rsp_entry_hits),
      .rsp_attempts_seen   (rsp_attempts_seen),
      .rsp_blocked_seen    (rsp_blocked_seen),
      .rsp_allowed_seen    (rsp_allowed_seen),
      .rsp_expired_seen    (rsp_expired_seen),
      .rsp_missing_seen    (rsp_missing_seen)
   );

endmodule
